// ===== rtl/mif_pkg.sv =====
// ----------------------------------------------------------------------------
// mif_pkg
// Shared constants and types for the multichannel iir filter: field widths,
// register indexes and the packed layout of one channel's history row.
// ----------------------------------------------------------------------------
package mif_pkg;

  localparam int CHANNELS  = 8;
  localparam int MAX_ORDER = 3;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int Y_W      = 24;
  localparam int ORDER_W  = 2;

  // coefficient fraction bits and output history fraction bits
  localparam int COEF_FRAC = 20;
  localparam int Y_FRAC    = 8;

  // b*x product, a*y product and the exact accumulator
  localparam int BX_W  = COEF_W + SAMPLE_W;
  localparam int AY_W  = COEF_W + Y_W;
  localparam int ACC_W = AY_W + 4;

  localparam int YW_W = ACC_W - COEF_FRAC;
  localparam int FW_W = Y_W + 1 - Y_FRAC;

  localparam logic [ORDER_W-1:0]       ORDER_RESET = ORDER_W'(2);
  localparam logic signed [COEF_W-1:0] COEF_ONE    = COEF_W'(1 << COEF_FRAC);

  typedef enum logic [2:0] {
    CFG_ORDER = 3'd0,
    CFG_B0    = 3'd1,
    CFG_B1    = 3'd2,
    CFG_B2    = 3'd3,
    CFG_B3    = 3'd4,
    CFG_A1    = 3'd5,
    CFG_A2    = 3'd6,
    CFG_A3    = 3'd7
  } cfg_index_t;

  // entry k holds the value k+1 steps back
  typedef struct packed {
    logic [MAX_ORDER-1:0][Y_W-1:0]      yh;
    logic [MAX_ORDER-1:0][SAMPLE_W-1:0] xh;
  } hist_row_t;

endpackage

// ===== rtl/multichannel_iir_filter_top.sv =====
// ----------------------------------------------------------------------------
// multichannel_iir_filter_top
// Direct form I iir filter, order 0 to 3, over interleaved channels, with
// per-channel histories kept in one row-wide memory.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output is not stalled and no item
// shares its channel with any of the three ahead of it; such an item waits for
// their write back, so one channel alone finishes read, multiply, sum and write back before its next item is taken.
// reset: configuration and valid registers return to their reset values and all
// histories read as zero at once through per-channel valid bits; no clearing pass.
module multichannel_iir_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [2:0]                          cfg_index,
  input  logic [mif_pkg::COEF_W-1:0]          cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mif_pkg::CH_W-1:0]            channel,
  input  logic signed [mif_pkg::SAMPLE_W-1:0] sample,
  input  logic                                block_end,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mif_pkg::CH_W-1:0]            out_channel,
  output logic signed [mif_pkg::SAMPLE_W-1:0] filtered,
  output logic                                saturated,
  output logic                                out_block_end
);

  localparam int MO = mif_pkg::MAX_ORDER;

  // configuration registers
  logic [mif_pkg::ORDER_W-1:0]       filter_order;
  logic signed [mif_pkg::COEF_W-1:0] coef_b [0:MO];
  logic signed [mif_pkg::COEF_W-1:0] coef_a [1:MO];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= mif_pkg::ORDER_RESET;
      coef_b[0]    <= mif_pkg::COEF_ONE;
      for (int j = 1; j <= MO; j++) begin
        coef_b[j] <= '0;
        coef_a[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (mif_pkg::cfg_index_t'(cfg_index))
        mif_pkg::CFG_ORDER: filter_order <= cfg_data[mif_pkg::ORDER_W-1:0];
        mif_pkg::CFG_B0:    coef_b[0] <= cfg_data;
        mif_pkg::CFG_B1:    coef_b[1] <= cfg_data;
        mif_pkg::CFG_B2:    coef_b[2] <= cfg_data;
        mif_pkg::CFG_B3:    coef_b[3] <= cfg_data;
        mif_pkg::CFG_A1:    coef_a[1] <= cfg_data;
        mif_pkg::CFG_A2:    coef_a[2] <= cfg_data;
        mif_pkg::CFG_A3:    coef_a[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                      s1_v, s2_v, s3_v;
  logic [mif_pkg::CH_W-1:0]  s1_ch, s2_ch, s3_ch;
  logic                      out_mv, s3_free, s2_free, s1_free;
  logic                      hazard, in_acc;

  assign out_mv  = s3_v && (!out_valid || out_ready);
  assign s3_free = !s3_v || out_mv;
  assign s2_free = !s2_v || s3_free;
  assign s1_free = !s1_v || s2_free;

  // interlock: a channel's row is re-read only after its write back
  assign hazard = (s1_v && (s1_ch == channel)) ||
                  (s2_v && (s2_ch == channel)) ||
                  (s3_v && (s3_ch == channel));

  assign in_ready = s1_free && !hazard;
  assign in_acc   = in_valid && in_ready;

  // history memory, one row per channel
  mif_pkg::hist_row_t hist_mem [mif_pkg::CHANNELS];
  mif_pkg::hist_row_t rd_row;
  mif_pkg::hist_row_t wr_row;
  logic [mif_pkg::CHANNELS-1:0] row_valid;
  logic                         rd_valid;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row <= hist_mem[channel];
    end
    if (out_mv) begin
      hist_mem[s3_ch] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_valid <= row_valid[channel];
      end
      if (out_mv) begin
        row_valid[s3_ch] <= 1'b1;
      end
    end
  end

  // stage 1: history row arrives, taps multiplied
  logic signed [mif_pkg::SAMPLE_W-1:0] s1_x;
  logic                                s1_be;
  mif_pkg::hist_row_t                  s1_row;
  logic signed [mif_pkg::BX_W-1:0]     bx0_c;
  logic signed [mif_pkg::BX_W-1:0]     bx_c [MO];
  logic signed [mif_pkg::AY_W-1:0]     ay_c [MO];
  logic signed [mif_pkg::COEF_W-1:0]   bm, am;

  always_comb begin
    s1_row = rd_valid ? rd_row : '0;
    bx0_c  = coef_b[0] * s1_x;
    for (int j = 0; j < MO; j++) begin
      // taps beyond the order count as zero
      bm = (mif_pkg::ORDER_W'(j) < filter_order) ? coef_b[j+1] : '0;
      am = (mif_pkg::ORDER_W'(j) < filter_order) ? coef_a[j+1] : '0;
      bx_c[j] = bm * $signed(s1_row.xh[j]);
      ay_c[j] = am * $signed(s1_row.yh[j]);
    end
  end

  // stage 2: products registered, summed
  logic signed [mif_pkg::BX_W-1:0]     s2_bx0;
  logic signed [mif_pkg::BX_W-1:0]     s2_bx [MO];
  logic signed [mif_pkg::AY_W-1:0]     s2_ay [MO];
  logic signed [mif_pkg::SAMPLE_W-1:0] s2_x;
  logic                                s2_be;
  mif_pkg::hist_row_t                  s2_row;
  logic signed [mif_pkg::ACC_W-1:0]    bsum, asum, acc_c;

  always_comb begin
    bsum = mif_pkg::ACC_W'(s2_bx0);
    asum = '0;
    for (int j = 0; j < MO; j++) begin
      bsum = bsum + mif_pkg::ACC_W'(s2_bx[j]);
      asum = asum + mif_pkg::ACC_W'(s2_ay[j]);
    end
    acc_c = (bsum <<< mif_pkg::Y_FRAC) - asum;
  end

  // stage 3: round and saturate, write back, load result
  logic signed [mif_pkg::ACC_W-1:0]    s3_acc;
  logic signed [mif_pkg::SAMPLE_W-1:0] s3_x;
  logic                                s3_be;
  mif_pkg::hist_row_t                  s3_row;
  logic signed [mif_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [mif_pkg::YW_W-1:0]     y_wide;
  logic signed [mif_pkg::Y_W-1:0]      y_c;
  logic                                y_sat;
  logic signed [mif_pkg::Y_W:0]        y_rnd;
  logic signed [mif_pkg::FW_W-1:0]     f_wide;
  logic signed [mif_pkg::SAMPLE_W-1:0] filt_c;
  logic                                f_sat;

  always_comb begin
    acc_rnd = s3_acc + mif_pkg::ACC_W'(1 << (mif_pkg::COEF_FRAC - 1));
    y_wide  = acc_rnd[mif_pkg::ACC_W-1:mif_pkg::COEF_FRAC];
    // overflow when the bits above the y sign disagree with it
    y_sat = (y_wide[mif_pkg::YW_W-1:mif_pkg::Y_W-1] != '0) &&
            (y_wide[mif_pkg::YW_W-1:mif_pkg::Y_W-1] != '1);
    if (y_sat) begin
      y_c = y_wide[mif_pkg::YW_W-1] ? {1'b1, {(mif_pkg::Y_W-1){1'b0}}}
                                    : {1'b0, {(mif_pkg::Y_W-1){1'b1}}};
    end else begin
      y_c = y_wide[mif_pkg::Y_W-1:0];
    end

    y_rnd  = {y_c[mif_pkg::Y_W-1], y_c} + (mif_pkg::Y_W+1)'(1 << (mif_pkg::Y_FRAC - 1));
    f_wide = y_rnd[mif_pkg::Y_W:mif_pkg::Y_FRAC];
    f_sat  = f_wide[mif_pkg::FW_W-1] != f_wide[mif_pkg::FW_W-2];
    if (f_sat) begin
      filt_c = f_wide[mif_pkg::FW_W-1] ? {1'b1, {(mif_pkg::SAMPLE_W-1){1'b0}}}
                                       : {1'b0, {(mif_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      filt_c = f_wide[mif_pkg::SAMPLE_W-1:0];
    end
  end

  // shift only the first order entries of the row
  always_comb begin
    wr_row = s3_row;
    if (filter_order != '0) begin
      for (int j = 1; j < MO; j++) begin
        if (mif_pkg::ORDER_W'(j) < filter_order) begin
          wr_row.xh[j] = s3_row.xh[j-1];
          wr_row.yh[j] = s3_row.yh[j-1];
        end
      end
      wr_row.xh[0] = s3_x;
      wr_row.yh[0] = y_c;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= in_acc;
      end
      if (s2_free) begin
        s2_v <= s1_v;
      end
      if (s3_free) begin
        s3_v <= s2_v;
      end
      if (!out_valid || out_ready) begin
        out_valid <= s3_v;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch <= channel;
      s1_x  <= sample;
      s1_be <= block_end;
    end
    if (s1_v && s2_free) begin
      s2_ch  <= s1_ch;
      s2_x   <= s1_x;
      s2_be  <= s1_be;
      s2_row <= s1_row;
      s2_bx0 <= bx0_c;
      for (int j = 0; j < MO; j++) begin
        s2_bx[j] <= bx_c[j];
        s2_ay[j] <= ay_c[j];
      end
    end
    if (s2_v && s3_free) begin
      s3_ch  <= s2_ch;
      s3_x   <= s2_x;
      s3_be  <= s2_be;
      s3_row <= s2_row;
      s3_acc <= acc_c;
    end
    if (out_mv) begin
      out_channel   <= s3_ch;
      filtered      <= filt_c;
      saturated     <= y_sat || f_sat;
      out_block_end <= s3_be;
    end
  end

endmodule
